@@ rtl/smef_pkg.sv @@
`default_nettype none

package smef_pkg;

   // Number of samples held in the sliding window.
   localparam int WINDOW = 5;

   localparam int SAMPLE_W = 16;
   localparam int GAIN_W   = 16;
   localparam int ACC_W    = 32;
   localparam int FRAC_W   = 16;

   // Age of a held sample: 0 for the newest, WINDOW-1 for the oldest.
   localparam int AGE_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam logic [AGE_W-1:0] AGE_OLDEST = AGE_W'(WINDOW - 1);

   localparam int MEDIAN_IDX = WINDOW / 2;

   localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(6554);

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [AGE_W-1:0]           age_type;

   // State that one cell of the sorted chain shows to its neighbors.
   typedef struct packed {
      logic       valid;
      logic       greater;   // not valid, or value above the incoming sample
      age_type    age;
      sample_type value;
   } cell_link_type;

endpackage

`default_nettype wire

@@ rtl/smef_cell.sv @@
`default_nettype none

module smef_cell (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       insert,
   input  wire smef_pkg::sample_type sample,
   input  wire smef_pkg::cell_link_type left_link,
   input  wire smef_pkg::cell_link_type right_link,
   input  wire                       removed_below,
   output smef_pkg::cell_link_type   self_link,
   output logic                      removed_through,
   output smef_pkg::sample_type      value_next,
   output logic                      valid_next
);

   logic                 valid_ff;
   logic                 valid_in;
   smef_pkg::sample_type value_ff;
   smef_pkg::sample_type value_in;
   smef_pkg::age_type    age_ff;
   smef_pkg::age_type    age_in;
   logic                 greater;
   logic                 remove_self;
   logic                 past_removal;
   logic                 cur_greater;
   logic                 prev_greater;
   smef_pkg::sample_type cur_value;
   smef_pkg::sample_type prev_value;
   smef_pkg::age_type    cur_age;
   smef_pkg::age_type    prev_age;

   assign greater      = !valid_ff || (value_ff > sample);
   assign remove_self  = valid_ff && (age_ff == smef_pkg::AGE_OLDEST);
   assign past_removal = removed_below || remove_self;

   assign self_link.valid   = valid_ff;
   assign self_link.greater = greater;
   assign self_link.age     = age_ff;
   assign self_link.value   = value_ff;

   assign removed_through = past_removal;

   // At or above the evicted entry the list is first closed up by one place,
   // so this cell sees its right neighbor as its own entry and itself (or,
   // for the evicted cell, its left neighbor) as the entry below.
   always_comb begin
      if (past_removal) begin
         cur_greater = right_link.greater;
         cur_value   = right_link.value;
         cur_age     = right_link.age;
         if (remove_self) begin
            prev_greater = left_link.greater;
            prev_value   = left_link.value;
            prev_age     = left_link.age;
         end else begin
            prev_greater = greater;
            prev_value   = value_ff;
            prev_age     = age_ff;
         end
      end else begin
         cur_greater  = greater;
         cur_value    = value_ff;
         cur_age      = age_ff;
         prev_greater = left_link.greater;
         prev_value   = left_link.value;
         prev_age     = left_link.age;
      end

      if (!cur_greater) begin
         value_in = cur_value;
         age_in   = cur_age + smef_pkg::age_type'(1);
      end else if (prev_greater) begin
         value_in = prev_value;
         age_in   = prev_age + smef_pkg::age_type'(1);
      end else begin
         value_in = sample;
         age_in   = '0;
      end

      valid_in = valid_ff || left_link.valid;
   end

   assign value_next = value_in;
   assign valid_next = valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (insert) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (insert) begin
         value_ff <= value_in;
         age_ff   <= age_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/smef_ema.sv @@
`default_nettype none

module smef_ema (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 update,
   input  wire [smef_pkg::GAIN_W-1:0]          gain,
   input  wire smef_pkg::sample_type           sample,
   output smef_pkg::sample_type                smoothed_next
);

   logic signed [smef_pkg::ACC_W-1:0]                    acc_ff;
   logic signed [smef_pkg::ACC_W-1:0]                    acc_in;
   logic signed [smef_pkg::ACC_W:0]                      diff;
   logic signed [smef_pkg::GAIN_W:0]                     gain_s;
   logic signed [smef_pkg::ACC_W+smef_pkg::GAIN_W+1:0]   prod;
   logic signed [smef_pkg::ACC_W+smef_pkg::GAIN_W+1:0]   step;

   // The difference needs one bit beyond the accumulator; the arithmetic
   // shift of the product gives the floor of the scaled step.
   assign diff   = $signed({sample[smef_pkg::SAMPLE_W-1], sample, {smef_pkg::FRAC_W{1'b0}}})
                 - $signed({acc_ff[smef_pkg::ACC_W-1], acc_ff});
   assign gain_s = $signed({1'b0, gain});
   assign prod   = gain_s * diff;
   assign step   = prod >>> smef_pkg::FRAC_W;
   assign acc_in = acc_ff + step[smef_pkg::ACC_W-1:0];

   assign smoothed_next = acc_in[smef_pkg::ACC_W-1 -: smef_pkg::SAMPLE_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (update) begin
         acc_ff <= acc_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/sliding_median_and_ema_filter_unit.sv @@
`default_nettype none

// Channel  Direction  Handshake              Payload
// req      in         req_valid/req_ready    req_sample
// rsp      out        rsp_valid/rsp_ready    rsp_median_valid, rsp_median_value,
//                                            rsp_smoothed_value
// csr      in         csr_valid/csr_ready    csr_smoothing_gain
//
// One item per cycle while the result is not stalled; its result appears in the cycle after the item is taken.
// The window is a sorted row of cells; one evicts the oldest entry and one
// takes the new sample in the same cycle, and the low-pass update is one
// multiply and add. Reset clears the cell valid bits, the accumulator and the
// gain (to 6554). A stalled result holds the output register; a new item is
// taken only when that register is empty or being emptied in the same cycle.

module sliding_median_and_ema_filter_unit (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_ready,
   input  wire signed [15:0]                req_sample,
   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output logic                             rsp_median_valid,
   output logic signed [15:0]               rsp_median_value,
   output logic signed [15:0]               rsp_smoothed_value,
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire [15:0]                       csr_smoothing_gain
);

   localparam int W = smef_pkg::WINDOW;

   logic                          accept;
   logic [smef_pkg::GAIN_W-1:0]   gain_ff;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic                          median_valid_ff;
   smef_pkg::sample_type          median_value_ff;
   smef_pkg::sample_type          median_value_in;
   smef_pkg::sample_type          smoothed_ff;
   smef_pkg::sample_type          smoothed_next;

   smef_pkg::cell_link_type       links [W];
   smef_pkg::sample_type          values_next [W];
   logic [W-1:0]                  valids_next;
   logic [W:0]                    removed_chain;
   smef_pkg::cell_link_type       edge_low;
   smef_pkg::cell_link_type       edge_high;

   assign csr_ready = 1'b1;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // Below the first cell sits a filled slot that never exceeds the sample;
   // above the last sits an empty slot that always does.
   assign edge_low.valid    = 1'b1;
   assign edge_low.greater  = 1'b0;
   assign edge_low.age      = '0;
   assign edge_low.value    = '0;
   assign edge_high.valid   = 1'b0;
   assign edge_high.greater = 1'b1;
   assign edge_high.age     = '0;
   assign edge_high.value   = '0;

   assign removed_chain[0] = 1'b0;

   for (genvar i = 0; i < W; i++) begin : g_cell
      smef_pkg::cell_link_type left_link;
      smef_pkg::cell_link_type right_link;

      if (i == 0) begin : g_first
         assign left_link = edge_low;
      end else begin : g_mid_left
         assign left_link = links[i-1];
      end
      if (i == W - 1) begin : g_last
         assign right_link = edge_high;
      end else begin : g_mid_right
         assign right_link = links[i+1];
      end

      smef_cell u_cell (
         .clock           (clock),
         .reset           (reset),
         .insert          (accept),
         .sample          (req_sample),
         .left_link       (left_link),
         .right_link      (right_link),
         .removed_below   (removed_chain[i]),
         .self_link       (links[i]),
         .removed_through (removed_chain[i+1]),
         .value_next      (values_next[i]),
         .valid_next      (valids_next[i])
      );
   end

   smef_ema u_ema (
      .clock         (clock),
      .reset         (reset),
      .update        (accept),
      .gain          (gain_ff),
      .sample        (req_sample),
      .smoothed_next (smoothed_next)
   );

   assign median_value_in = valids_next[W-1] ? values_next[smef_pkg::MEDIAN_IDX] : '0;
   assign rsp_valid_in    = accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff      <= smef_pkg::GAIN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            gain_ff <= csr_smoothing_gain;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         median_valid_ff <= valids_next[W-1];
         median_value_ff <= median_value_in;
         smoothed_ff     <= smoothed_next;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_median_valid   = median_valid_ff;
   assign rsp_median_value   = median_value_ff;
   assign rsp_smoothed_value = smoothed_ff;

`ifndef ASSERT_OFF
   logic [W-1:0] cell_valid;
   logic [W-1:0] cell_oldest;

   for (genvar k = 0; k < W; k++) begin : g_chk
      assign cell_valid[k]  = links[k].valid;
      assign cell_oldest[k] = links[k].valid && (links[k].age == smef_pkg::AGE_OLDEST);
   end

   // Filled cells always form an unbroken run from the low end.
   a_fill_prefix: assert property (@(posedge clock) disable iff (reset)
      ((cell_valid + W'(1)) & cell_valid) == '0)
      else $error("cell valid bits are not a prefix");

   a_one_oldest: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cell_oldest))
      else $error("more than one oldest entry in the window");

   a_full_evicts: assert property (@(posedge clock) disable iff (reset)
      cell_valid[W-1] |-> $onehot(cell_oldest))
      else $error("full window without exactly one oldest entry");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted item gave no result");
`endif

endmodule

`default_nettype wire
